FILE: design/hsv_pkg.sv
// Shared types, constants and helpers for the HSV to RGB pipeline.
package hsv_pkg;

   localparam int CHANNEL_BITS   = 8;
   localparam int HUE_BITS       = 13;
   localparam int SECTOR_BITS    = 3;
   localparam int REM_BITS       = 10;
   localparam int FRAC_BITS      = 8;
   localparam int SECTOR_COUNT   = 6;
   localparam int FRAC_PRE_SHIFT = 2;
   localparam int RECIP_BITS     = 13;
   localparam int RECIP_SHIFT    = 16;
   localparam int FRAC_PROD_BITS = REM_BITS + FRAC_PRE_SHIFT + RECIP_BITS;
   localparam int PROD_BITS      = 2 * CHANNEL_BITS;

   localparam logic [HUE_BITS-1:0]     HUE_TURN   = 13'd5760;
   localparam logic [HUE_BITS-1:0]     HUE_SECTOR = 13'd960;
   localparam logic [RECIP_BITS-1:0]   FRAC_RECIP = 13'd4370;
   localparam logic [CHANNEL_BITS-1:0] MAXV       = '1;
   localparam logic [FRAC_BITS:0]      FRAC_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [SECTOR_BITS-1:0] SEC_RED     = 3'd0;
   localparam logic [SECTOR_BITS-1:0] SEC_YELLOW  = 3'd1;
   localparam logic [SECTOR_BITS-1:0] SEC_GREEN   = 3'd2;
   localparam logic [SECTOR_BITS-1:0] SEC_CYAN    = 3'd3;
   localparam logic [SECTOR_BITS-1:0] SEC_BLUE    = 3'd4;
   localparam logic [SECTOR_BITS-1:0] SEC_MAGENTA = 3'd5;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } hsv_req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } hsv_rsp_type;

   typedef struct packed {
      logic [SECTOR_BITS-1:0]  sector;
      logic [FRAC_BITS-1:0]    frac;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
   } hsv_frac_type;

   typedef struct packed {
      logic [SECTOR_BITS-1:0]  sector;
      logic [CHANNEL_BITS-1:0] brightness;
      logic [PROD_BITS-1:0]    pprod;
      logic [PROD_BITS-1:0]    qprod;
      logic [PROD_BITS-1:0]    tprod;
   } hsv_prod_type;

   // floor(x / MAXV) for any product of two channel values
   function automatic logic [CHANNEL_BITS-1:0] div_maxv(input logic [PROD_BITS-1:0] x);
      logic [PROD_BITS:0] sum;
      sum = {1'b0, x} + (PROD_BITS+1)'(x >> CHANNEL_BITS) + (PROD_BITS+1)'(1);
      return sum[CHANNEL_BITS +: CHANNEL_BITS];
   endfunction

endpackage

FILE: design/hsv_sector.sv
// Out-of-range hue to zero, sector split and 8-bit fraction within the sector (two stages).
module hsv_sector (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  hsv_pkg::hsv_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output hsv_pkg::hsv_frac_type out_data
);
   import hsv_pkg::*;

   logic                    a_valid_ff;
   logic [SECTOR_BITS-1:0]  a_sector_ff;
   logic [SECTOR_BITS-1:0]  a_sector_in;
   logic [REM_BITS-1:0]     a_rem_ff;
   logic [REM_BITS-1:0]     a_rem_in;
   logic [CHANNEL_BITS-1:0] a_sat_ff;
   logic [CHANNEL_BITS-1:0] a_bri_ff;

   logic                    b_valid_ff;
   hsv_frac_type            b_data_ff;
   hsv_frac_type            b_data_in;

   logic                    en_a;
   logic                    en_b;
   logic [FRAC_PROD_BITS-1:0] frac_prod;

   assign en_b     = !b_valid_ff || !out_stall;
   assign en_a     = !a_valid_ff || en_b;
   assign in_stall = !en_a;

   always_comb begin
      logic [HUE_BITS-1:0] hh;
      logic [HUE_BITS-1:0] bound;
      logic [HUE_BITS-1:0] base;
      hh = in_data.hue;
      if (hh >= HUE_TURN) begin
         hh = '0;
      end
      a_sector_in = SEC_RED;
      base        = '0;
      for (int k = 1; k < SECTOR_COUNT; k++) begin
         bound = HUE_BITS'(k * int'(HUE_SECTOR));
         if (hh >= bound) begin
            a_sector_in = SECTOR_BITS'(k);
            base        = bound;
         end
      end
      a_rem_in = REM_BITS'(hh - base);
   end

   always_comb begin
      frac_prod = FRAC_PROD_BITS'({a_rem_ff, {FRAC_PRE_SHIFT{1'b0}}})
                * FRAC_PROD_BITS'(FRAC_RECIP);
      b_data_in.sector     = a_sector_ff;
      b_data_in.frac       = frac_prod[RECIP_SHIFT +: FRAC_BITS];
      b_data_in.saturation = a_sat_ff;
      b_data_in.brightness = a_bri_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= in_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_sector_ff <= a_sector_in;
         a_rem_ff    <= a_rem_in;
         a_sat_ff    <= in_data.saturation;
         a_bri_ff    <= in_data.brightness;
      end
      if (en_b) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

FILE: design/hsv_scale.sv
// Saturation scaling and brightness products for p, q and t (two stages).
module hsv_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  hsv_pkg::hsv_frac_type in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output hsv_pkg::hsv_prod_type out_data
);
   import hsv_pkg::*;

   logic                    c_valid_ff;
   logic [SECTOR_BITS-1:0]  c_sector_ff;
   logic [CHANNEL_BITS-1:0] c_sat_ff;
   logic [CHANNEL_BITS-1:0] c_bri_ff;
   logic [CHANNEL_BITS-1:0] c_kq_ff;
   logic [CHANNEL_BITS-1:0] c_kq_in;
   logic [CHANNEL_BITS-1:0] c_kt_ff;
   logic [CHANNEL_BITS-1:0] c_kt_in;

   logic                    d_valid_ff;
   hsv_prod_type            d_data_ff;
   hsv_prod_type            d_data_in;

   logic                    en_c;
   logic                    en_d;
   logic [CHANNEL_BITS+FRAC_BITS-1:0] sf_prod;
   logic [CHANNEL_BITS+FRAC_BITS:0]   sfc_prod;

   assign en_d     = !d_valid_ff || !out_stall;
   assign en_c     = !c_valid_ff || en_d;
   assign in_stall = !en_c;

   always_comb begin
      sf_prod  = (CHANNEL_BITS+FRAC_BITS)'(in_data.saturation)
               * (CHANNEL_BITS+FRAC_BITS)'(in_data.frac);
      sfc_prod = (CHANNEL_BITS+FRAC_BITS+1)'(in_data.saturation)
               * (CHANNEL_BITS+FRAC_BITS+1)'(FRAC_ONE - {1'b0, in_data.frac});
      c_kq_in  = MAXV - sf_prod[FRAC_BITS +: CHANNEL_BITS];
      c_kt_in  = MAXV - sfc_prod[FRAC_BITS +: CHANNEL_BITS];
   end

   always_comb begin
      d_data_in.sector     = c_sector_ff;
      d_data_in.brightness = c_bri_ff;
      d_data_in.pprod      = PROD_BITS'(c_bri_ff) * PROD_BITS'(MAXV - c_sat_ff);
      d_data_in.qprod      = PROD_BITS'(c_bri_ff) * PROD_BITS'(c_kq_ff);
      d_data_in.tprod      = PROD_BITS'(c_bri_ff) * PROD_BITS'(c_kt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (en_c) begin
            c_valid_ff <= in_valid;
         end
         if (en_d) begin
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_sector_ff <= in_data.sector;
         c_sat_ff    <= in_data.saturation;
         c_bri_ff    <= in_data.brightness;
         c_kq_ff     <= c_kq_in;
         c_kt_ff     <= c_kt_in;
      end
      if (en_d) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

FILE: design/hsv_mix.sv
// Division by full scale, six-way channel mapping and the output register.
module hsv_mix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  hsv_pkg::hsv_prod_type in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output hsv_pkg::hsv_rsp_type  out_data
);
   import hsv_pkg::*;

   logic        e_valid_ff;
   hsv_rsp_type e_data_ff;
   hsv_rsp_type e_data_in;
   logic        en_e;

   logic [CHANNEL_BITS-1:0] p_val;
   logic [CHANNEL_BITS-1:0] q_val;
   logic [CHANNEL_BITS-1:0] t_val;
   logic [CHANNEL_BITS-1:0] v_val;

   assign en_e     = !e_valid_ff || !out_stall;
   assign in_stall = !en_e;

   always_comb begin
      p_val = div_maxv(in_data.pprod);
      q_val = div_maxv(in_data.qprod);
      t_val = div_maxv(in_data.tprod);
      v_val = in_data.brightness;
      unique case (in_data.sector)
         SEC_RED: begin
            e_data_in = '{red: v_val, green: t_val, blue: p_val};
         end
         SEC_YELLOW: begin
            e_data_in = '{red: q_val, green: v_val, blue: p_val};
         end
         SEC_GREEN: begin
            e_data_in = '{red: p_val, green: v_val, blue: t_val};
         end
         SEC_CYAN: begin
            e_data_in = '{red: p_val, green: q_val, blue: v_val};
         end
         SEC_BLUE: begin
            e_data_in = '{red: t_val, green: p_val, blue: v_val};
         end
         default: begin
            e_data_in = '{red: v_val, green: p_val, blue: q_val};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en_e) begin
         e_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_data_ff <= e_data_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_data_ff;

endmodule

FILE: design/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: five-stage pipeline, one request per cycle.
// Stages: a and b in hsv_sector, c and d in hsv_scale, e in hsv_mix; a request
// passes through them in that order and reaches rsp_ from the output register e.
// Throughput: 1 request per cycle; a stage holds only while its successor is full
// and held, so only a stalled output register holds the pipeline.
// Reset: synchronous; clears every stage valid bit, the pipeline comes up empty.
module hsv_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hsv_pkg::hsv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsv_pkg::hsv_rsp_type rsp_data
);
   import hsv_pkg::*;

   logic         frac_valid;
   logic         frac_stall;
   hsv_frac_type frac_data;
   logic         prod_valid;
   logic         prod_stall;
   hsv_prod_type prod_data;

   hsv_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (frac_valid),
      .out_stall (frac_stall),
      .out_data  (frac_data)
   );

   hsv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frac_valid),
      .in_stall  (frac_stall),
      .in_data   (frac_data),
      .out_valid (prod_valid),
      .out_stall (prod_stall),
      .out_data  (prod_data)
   );

   hsv_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_stall  (prod_stall),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

FILE: design/hsv_checker.sv
// Port-level checks for the HSV to RGB converter and their binding.
module hsv_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input hsv_pkg::hsv_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input hsv_pkg::hsv_rsp_type rsp_data
);
   import hsv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   a_gray_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.saturation == '0)
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid
          && rsp_data.red   == $past(req_data.brightness, 5)
          && rsp_data.green == $past(req_data.brightness, 5)
          && rsp_data.blue  == $past(req_data.brightness, 5))
      else $error("gray request did not return its brightness on time");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (.*);
